### rtl/core/reed_solomon_parity_encoder_defines.svh
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_defines
// Assertion macros used by the port-level checker of the parity encoder.
// ----------------------------------------------------------------------------
`ifndef REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH
`define REED_SOLOMON_PARITY_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants, types and GF(256) helpers of the Reed-Solomon parity
// encoder (field polynomial 0x11D).
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int MAX_PARITY = 32;
  localparam int IDX_W      = $clog2(MAX_PARITY);
  localparam int CNT_W      = $clog2(MAX_PARITY + 1);

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PARITY_COUNT_RST = 6'd10;

  localparam logic [8:0] FIELD_POLY = 9'h11D;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  typedef logic [7:0] exp_tbl_t [256];

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       msg_step;
    logic       flush;
    logic       gen_wr;
    logic [7:0] gen_byte;
    logic [7:0] fb;
    logic       out_shift;
  } cell_ctrl_t;

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t   t;
    logic [8:0] x;
    x = 9'h001;
    for (int k = 0; k < 256; k++) begin
      t[k] = x[7:0];
      x    = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ FIELD_POLY;
      end
    end
    return t;
  endfunction

  // alpha^e for e in 0..255; alpha^255 wraps to 1.
  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  // Nine-bit two's complement exponent to byte; negative is the zero element.
  function automatic logic [7:0] log_to_byte(logic [8:0] v);
    return v[8] ? 8'h00 : EXP_TBL[v[7:0]];
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'h00);
    end
    return acc;
  endfunction

  // Zero counts as one parity symbol; large counts saturate.
  function automatic logic [CNT_W-1:0] eff_count(logic [PC_W-1:0] pc);
    logic [CNT_W-1:0] n;
    if (pc == '0) begin
      n = CNT_W'(1);
    end else if (int'(pc) > MAX_PARITY) begin
      n = CNT_W'(MAX_PARITY);
    end else begin
      n = CNT_W'(pc);
    end
    return n;
  endfunction

endpackage

### rtl/core/rsp_cell.sv
// ----------------------------------------------------------------------------
// rsp_cell
// One remainder position: holds a generator coefficient, a remainder byte and
// an output byte, and passes both bytes on to the next higher position.
// ----------------------------------------------------------------------------
module rsp_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rsp_pkg::cell_ctrl_t ctrl,
  input  logic               active,
  input  logic               gen_sel,
  input  logic [7:0]         rem_prev,
  input  logic [7:0]         obuf_prev,
  output logic [7:0]         rem,
  output logic [7:0]         obuf
);

  logic [7:0] gen_r, gen_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] obuf_r, obuf_nxt;
  logic [7:0] rem_upd;

  assign rem_upd = rem_prev ^ rsp_pkg::gf_mul(ctrl.fb, gen_r);

  always_comb begin
    gen_nxt = gen_r;
    if (ctrl.gen_wr && gen_sel) begin
      gen_nxt = ctrl.gen_byte;
    end
  end

  always_comb begin
    priority if (ctrl.flush) begin
      rem_nxt = 8'h00;
    end else if (ctrl.msg_step && active) begin
      rem_nxt = rem_upd;
    end else begin
      rem_nxt = rem_r;
    end
  end

  // A flush captures the final remainder for the output shift line.
  always_comb begin
    priority if (ctrl.flush) begin
      obuf_nxt = active ? rem_upd : 8'h00;
    end else if (ctrl.out_shift) begin
      obuf_nxt = obuf_prev;
    end else begin
      obuf_nxt = obuf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 8'h00;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r  <= gen_nxt;
    obuf_r <= obuf_nxt;
  end

  assign rem  = rem_r;
  assign obuf = obuf_r;

endmodule

### rtl/core/reed_solomon_parity_encoder.sv
// The first parity word is valid in the cycle after the last message word is accepted.
// One input word per cycle while in_tready is high; each codeword drains n parity
// words, one per cycle while out_tready is high, through the single output shift line.
// Message words of the next codeword overlap the drain; its last word waits
// until the drain ends. Reset clears remainder, output count and sets
// parity_count to 10; the generator table is undefined until loaded.
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// GF(256) Reed-Solomon parity encoder built as a row of remainder cells with
// a parallel feedback, one message symbol per cycle while in_tready is high.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wdata,    // parity_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // coeff_index[4:0], symbol_log[13:5], zero
  input  logic        in_tuser,     // op
  input  logic        in_tlast,     // last_symbol
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // parity_byte
  output logic        out_tlast     // last_parity
);

  localparam int MAXP = rsp_pkg::MAX_PARITY;

  logic [rsp_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [rsp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rsp_pkg::CNT_W-1:0] n_eff;
  logic [rsp_pkg::IDX_W-1:0] top_idx;

  logic [4:0] coeff_index;
  logic [8:0] symbol_log;
  logic       in_acc, out_acc;

  rsp_pkg::cell_ctrl_t ctrl;

  logic [7:0] rem_w  [MAXP];
  logic [7:0] obuf_w [MAXP];

  assign coeff_index = in_tdata[4:0];
  assign symbol_log  = in_tdata[13:5];

  assign n_eff   = rsp_pkg::eff_count(pc_r);
  assign top_idx = rsp_pkg::IDX_W'(n_eff - 1'b1);

  // A closing message word needs the output line, free once the drain ends.
  assign in_tready = (cnt_r == '0) || ((cnt_r == rsp_pkg::CNT_W'(1)) && out_tready) ||
                     !((in_tuser == rsp_pkg::OP_MSG) && in_tlast);

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    ctrl.msg_step  = in_acc && (in_tuser == rsp_pkg::OP_MSG);
    ctrl.flush     = in_acc && (in_tuser == rsp_pkg::OP_MSG) && in_tlast;
    ctrl.gen_wr    = in_acc && (in_tuser == rsp_pkg::OP_LOAD);
    ctrl.gen_byte  = rsp_pkg::log_to_byte(symbol_log);
    ctrl.fb        = rem_w[top_idx] ^ rsp_pkg::log_to_byte(symbol_log);
    ctrl.out_shift = out_acc;
  end

  for (genvar i = 0; i < MAXP; i++) begin : g_cell
    logic [7:0] rem_prev;
    logic [7:0] obuf_prev;
    if (i == 0) begin : g_first
      assign rem_prev  = 8'h00;
      assign obuf_prev = 8'h00;
    end else begin : g_rest
      assign rem_prev  = rem_w[i-1];
      assign obuf_prev = obuf_w[i-1];
    end

    rsp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .active    (i < int'(n_eff)),
      .gen_sel   (int'(coeff_index) == i),
      .rem_prev  (rem_prev),
      .obuf_prev (obuf_prev),
      .rem       (rem_w[i]),
      .obuf      (obuf_w[i])
    );
  end

  always_comb begin
    pc_nxt = pc_r;
    if (cfg_wr_en) begin
      pc_nxt = cfg_wdata;
    end
  end

  always_comb begin
    priority if (ctrl.flush) begin
      cnt_nxt = n_eff;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= rsp_pkg::PARITY_COUNT_RST;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // While parity drains and the count is unchanged, the highest active position holds the next parity word.
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = obuf_w[top_idx];
  assign out_tlast  = (cnt_r == rsp_pkg::CNT_W'(1));

endmodule

### rtl/core/rsp_checker.sv
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks of the parity encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "reed_solomon_parity_encoder_defines.svh"

module rsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  logic last_msg_acc;
  logic final_out_acc;
  logic closing_ready;

  assign last_msg_acc  = in_tvalid && in_tready && (in_tuser == rsp_pkg::OP_MSG) && in_tlast;
  assign final_out_acc = out_tvalid && out_tready && out_tlast;
  assign closing_ready = in_tready && (in_tuser == rsp_pkg::OP_MSG) && in_tlast;

  `RSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output word changed")
  `RSP_ASSERT_NEXT(a_parity_follows, clk, rst_n, last_msg_acc, out_tvalid,
    "no parity after the closing message word")
  `RSP_ASSERT_IMPLY(a_load_ready, clk, rst_n, in_tvalid && (in_tuser == rsp_pkg::OP_LOAD),
    in_tready, "coefficient load was stalled")
  `RSP_ASSERT_NEXT(a_drain_ends, clk, rst_n, final_out_acc && !last_msg_acc, !out_tvalid,
    "output word after the final parity word")
  `RSP_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_tvalid && !(out_tready && out_tlast),
    !closing_ready, "closing word taken while parity drains")

endmodule

bind reed_solomon_parity_encoder rsp_checker u_rsp_checker (.*);

### verif/reed_solomon_parity_encoder_checker.sv
// ----------------------------------------------------------------------------
// Parity encoder checker
// Watches the configuration port and both stream channels of the encoder.
// A GF(256) remainder model follows every accepted input word. Each parity
// word that the block delivers is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wdata,    // parity_count
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,     // coeff_index[4:0], symbol_log[13:5], zero
  input  logic        in_tuser,     // op
  input  logic        in_tlast,     // last_symbol
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,    // parity_byte
  input  logic        out_tlast,    // last_parity
  input  logic        end_of_test,
  output int          mismatch_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       tail;
  } parity_word_t;

  logic [7:0]               antilog [0:254];
  logic [8:0]               gen_log [rsp_pkg::MAX_PARITY];
  logic [7:0]               rem_bytes [rsp_pkg::MAX_PARITY];
  logic [rsp_pkg::PC_W-1:0] parity_count;
  parity_word_t             expected_parity [$];

  initial begin
    logic [7:0] v;
    v = 8'h01;
    for (int e = 0; e < 255; e++) begin
      antilog[e] = v;
      v = {v[6:0], 1'b0} ^ (v[7] ? rsp_pkg::FIELD_POLY[7:0] : 8'h00);
    end
  end

  // A negative exponent is the zero element; exponent 255 wraps to alpha^0.
  function automatic logic [7:0] log_value(logic [8:0] lg);
    if (lg[8]) begin
      return 8'h00;
    end
    return antilog[(lg[7:0] == 8'hFF) ? 8'h00 : lg[7:0]];
  endfunction

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    acc = 8'h00;
    x   = a;
    y   = b;
    while (y != 8'h00) begin
      if (y[0]) begin
        acc ^= x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? rsp_pkg::FIELD_POLY[7:0] : 8'h00);
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic int active_count();
    if (parity_count == '0) begin
      return 1;
    end
    if (int'(parity_count) > rsp_pkg::MAX_PARITY) begin
      return rsp_pkg::MAX_PARITY;
    end
    return int'(parity_count);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // One LFSR step. Entries above the active count are left alone, so a
  // count raised mid-codeword sees whatever they held before.
  task automatic encode_symbol(input logic [8:0] sym, input logic last_sym);
    int           n;
    logic [7:0]   fb;
    parity_word_t w;
    n  = active_count();
    fb = rem_bytes[n-1] ^ log_value(sym);
    for (int i = n - 1; i >= 1; i--) begin
      rem_bytes[i] = rem_bytes[i-1] ^ gf_times(fb, log_value(gen_log[i]));
    end
    rem_bytes[0] = gf_times(fb, log_value(gen_log[0]));
    if (last_sym) begin
      for (int i = 0; i < n; i++) begin
        w.value = rem_bytes[n-1-i];
        w.tail  = (i == n - 1);
        expected_parity.push_back(w);
      end
      foreach (rem_bytes[i]) begin
        rem_bytes[i] = 8'h00;
      end
    end
  endtask

  always @(posedge clk) begin
    parity_word_t want;
    if (!rst_n) begin
      parity_count = rsp_pkg::PARITY_COUNT_RST;
      foreach (rem_bytes[i]) begin
        rem_bytes[i] = 8'h00;
      end
      expected_parity.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_parity.size() == 0) begin
          report_mismatch($sformatf("parity word %02h with nothing expected", out_tdata));
        end else begin
          want = expected_parity.pop_front();
          if (out_tdata !== want.value) begin
            report_mismatch($sformatf("parity byte %02h, expected %02h",
                                      out_tdata, want.value));
          end
          if (out_tlast !== want.tail) begin
            report_mismatch($sformatf("last flag %b, expected %b on byte %02h",
                                      out_tlast, want.tail, want.value));
          end
        end
      end
      if (cfg_wr_en) begin
        parity_count = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == rsp_pkg::OP_LOAD) begin
          gen_log[in_tdata[4:0]] = in_tdata[13:5];
        end else begin
          encode_symbol(in_tdata[13:5], in_tlast);
        end
      end
      if (end_of_test && expected_parity.size() != 0) begin
        report_mismatch($sformatf("%0d parity words never arrived",
                                  expected_parity.size()));
        expected_parity.delete();
      end
    end
    pending_words = expected_parity.size();
  end

endmodule

### verif/reed_solomon_parity_encoder_tb.sv
// ----------------------------------------------------------------------------
// Parity encoder testbench
// Loads the generator table, runs directed codewords over the parity count
// extremes, then random codewords mixed with table reloads under several
// idle and stall patterns. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS  = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        end_of_test;
  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          ready_stall_pct;
  int          quiet_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  reed_solomon_parity_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  reed_solomon_parity_encoder_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .end_of_test    (end_of_test),
    .mismatch_count (mismatches),
    .pending_words  (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready) && !cfg_wr_en) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Mostly ordinary exponents, with zero elements and the wrap value mixed in.
  function automatic logic [8:0] rand_log();
    int r;
    r = $urandom_range(15);
    case (r)
      0:       return 9'h1FF;
      1:       return 9'($urandom_range(256, 511));
      2:       return 9'd255;
      3:       return 9'd0;
      default: return 9'($urandom_range(254));
    endcase
  endfunction

  task automatic push_word(input logic op, input logic [4:0] idx, input logic [8:0] lg,
                           input logic last_sym);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, lg, idx};
    in_tlast  <= last_sym;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Stops sending until every predicted parity word has been delivered.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_parity_count(input logic [5:0] value);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int         sent;
    int         len;
    int         pick;
    logic [8:0] lg;
    logic [5:0] count_value;

    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wdata       <= '0;
    in_tvalid       <= 1'b0;
    in_tdata        <= '0;
    in_tuser        <= rsp_pkg::OP_LOAD;
    in_tlast        <= 1'b0;
    end_of_test     <= 1'b0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table first so that no unwritten entry is ever read.
    for (int k = 0; k < rsp_pkg::MAX_PARITY; k++) begin
      case (k)
        0:       lg = 9'd255;
        1:       lg = 9'h1FF;
        2:       lg = 9'h100;
        3:       lg = 9'd254;
        4:       lg = 9'd0;
        default: lg = 9'($urandom_range(511));
      endcase
      push_word(rsp_pkg::OP_LOAD, 5'(k), lg, 1'($urandom_range(1)));
    end

    // Codewords at the reset count of ten, symbol extremes included.
    push_word(rsp_pkg::OP_MSG, 5'd31, 9'd0,   1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd0,  9'd254, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd21, 9'd255, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd10, 9'h1FF, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd5,  9'h100, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd31, 9'h0AA, 1'b1);
    push_word(rsp_pkg::OP_MSG, 5'd0,  9'h1FF, 1'b1);

    // A count of zero acts as one; counts above the table size saturate.
    set_parity_count(6'd0);
    push_word(rsp_pkg::OP_MSG, 5'd3, 9'd7,   1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd3, 9'd200, 1'b1);
    set_parity_count(6'd63);
    push_word(rsp_pkg::OP_MSG, 5'd1, 9'd100, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd2, 9'd255, 1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd4, 9'd13,  1'b1);
    set_parity_count(6'd33);
    push_word(rsp_pkg::OP_MSG, 5'd8, 9'd1,   1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd8, 9'd250, 1'b1);

    // Shrink the count in the middle of a codeword; the remainder is kept.
    set_parity_count(6'd32);
    push_word(rsp_pkg::OP_MSG, 5'd9,  9'd60,  1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd9,  9'd61,  1'b0);
    push_word(rsp_pkg::OP_MSG, 5'd9,  9'd62,  1'b0);
    set_parity_count(6'd5);
    push_word(rsp_pkg::OP_MSG, 5'd9,  9'd63,  1'b1);

    // A coefficient loaded above the count only shows once the count grows.
    set_parity_count(6'd3);
    push_word(rsp_pkg::OP_LOAD, 5'd20, 9'd77, 1'b1);
    push_word(rsp_pkg::OP_MSG,  5'd20, 9'd1,  1'b1);
    set_parity_count(6'd24);
    push_word(rsp_pkg::OP_MSG,  5'd11, 9'd90, 1'b0);
    push_word(rsp_pkg::OP_MSG,  5'd11, 9'd91, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct   = 0;
          ready_stall_pct = 0;
        end
        1: begin
          send_idle_pct   = 60;
          ready_stall_pct = 0;
        end
        2: begin
          send_idle_pct   = 0;
          ready_stall_pct = 60;
        end
        default: begin
          send_idle_pct   = 38;
          ready_stall_pct = 38;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_WORDS / 4) begin
        // Mostly small counts so codewords drain quickly, extremes now and then.
        pick = $urandom_range(19);
        case (pick)
          0:       count_value = 6'd0;
          1:       count_value = 6'd63;
          2:       count_value = 6'd32;
          3:       count_value = 6'($urandom_range(33, 63));
          default: count_value = 6'($urandom_range(1, 12));
        endcase
        set_parity_count(count_value);
        repeat ($urandom_range(2, 5)) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
              push_word(rsp_pkg::OP_LOAD, 5'($urandom_range(31)), rand_log(),
                        1'($urandom_range(1)));
              sent++;
            end
            push_word(rsp_pkg::OP_MSG, 5'($urandom_range(31)), rand_log(), k == len - 1);
            sent++;
          end
          if ($urandom_range(7) == 0) begin
            settle();
          end
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rsp_pkg.sv
rtl/core/rsp_cell.sv
rtl/core/reed_solomon_parity_encoder.sv
rtl/core/rsp_checker.sv
verif/reed_solomon_parity_encoder_checker.sv
verif/reed_solomon_parity_encoder_tb.sv
